### rtl/amg_pkg.sv
// shared codes, field widths and control types of the adjacency matrix graph store
`default_nettype none
package amg_pkg;
	localparam int OP_W   = 3;
	localparam int KEY_W  = 32;
	localparam int STAT_W = 3;
	localparam int DEG_W  = 5;
	localparam int VTOT_W = 5;
	localparam int ETOT_W = 9;
	localparam int OVAL_W = 32;
	localparam int IN_DATA_W  = 96;
	localparam int OUT_DATA_W = 96;

	localparam logic [OP_W-1:0] OP_ADD_VERTEX = 3'd0;
	localparam logic [OP_W-1:0] OP_ADD_EDGE   = 3'd1;
	localparam logic [OP_W-1:0] OP_REM_EDGE   = 3'd2;
	localparam logic [OP_W-1:0] OP_READ_EDGE  = 3'd3;
	localparam logic [OP_W-1:0] OP_SUCC       = 3'd4;
	localparam logic [OP_W-1:0] OP_PRED       = 3'd5;
	localparam logic [OP_W-1:0] OP_INFO       = 3'd6;
	localparam logic [OP_W-1:0] OP_NONE       = 3'd7;

	localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
	localparam logic [STAT_W-1:0] ST_UNKNOWN = 3'd1;
	localparam logic [STAT_W-1:0] ST_DUP     = 3'd2;
	localparam logic [STAT_W-1:0] ST_FULL    = 3'd3;
	localparam logic [STAT_W-1:0] ST_NO_EDGE = 3'd4;

	typedef struct packed {
		logic capture;
		logic match;
		logic exec;
		logic mirror;
		logic load_single;
		logic load_nbr;
		logic scan_inc;
	} amg_cmd_t;

	typedef struct packed {
		logic is_nop;
		logic is_list;
		logic need_mirror;
		logic row_empty;
		logic row_bit;
		logic rest_zero;
		logic can_load;
	} amg_stat_t;
endpackage
`default_nettype wire

### rtl/amg_ram.sv
// generic single write port ram with registered read
`default_nettype none
module amg_ram #(
	parameter int W = 32,
	parameter int D = 256
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);
	logic [W-1:0] mem [D];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

### rtl/amg_ctrl.sv
// operation sequencer of the graph store
`default_nettype none
module amg_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire amg_pkg::amg_stat_t stat,
	output amg_pkg::amg_cmd_t      cmd
);
	import amg_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_MATCH  = 3'd1;
	localparam logic [2:0] S_EXEC   = 3'd2;
	localparam logic [2:0] S_MIRROR = 3'd3;
	localparam logic [2:0] S_RESP   = 3'd4;
	localparam logic [2:0] S_SCAN   = 3'd5;

	logic [2:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) state_d = S_MATCH;
			end
			S_MATCH: begin
				cmd.match = 1'b1;
				state_d   = stat.is_nop ? S_IDLE : S_EXEC;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				if (stat.is_list) state_d = S_SCAN;
				else if (stat.need_mirror) state_d = S_MIRROR;
				else state_d = S_RESP;
			end
			S_MIRROR: begin
				cmd.mirror = 1'b1;
				state_d    = S_RESP;
			end
			S_RESP: begin
				if (stat.can_load) begin
					cmd.load_single = 1'b1;
					state_d         = S_IDLE;
				end
			end
			S_SCAN: begin
				if (stat.row_empty) begin
					if (stat.can_load) begin
						cmd.load_single = 1'b1;
						state_d         = S_IDLE;
					end
				end else if (stat.row_bit) begin
					if (stat.can_load) begin
						cmd.load_nbr = 1'b1;
						if (stat.rest_zero) state_d = S_IDLE;
						else cmd.scan_inc = 1'b1;
					end
				end else begin
					cmd.scan_inc = 1'b1;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

### rtl/amg_dp.sv
// key match, adjacency matrix, degree counters and result register
`default_nettype none
module amg_dp #(
	parameter int MV = 16,
	parameter int VW = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire amg_pkg::amg_cmd_t            cmd,
	output amg_pkg::amg_stat_t                stat,
	input  wire logic                         directed,
	input  wire logic [amg_pkg::OP_W-1:0]     op,
	input  wire logic [amg_pkg::KEY_W-1:0]    src_key,
	input  wire logic [amg_pkg::KEY_W-1:0]    dst_key,
	input  wire logic [amg_pkg::OVAL_W-1:0]   new_value,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [amg_pkg::STAT_W-1:0]        status,
	output logic                              found,
	output logic [amg_pkg::OVAL_W-1:0]        stored_value,
	output logic [amg_pkg::KEY_W-1:0]         neighbour_key,
	output logic [amg_pkg::DEG_W-1:0]         out_degree,
	output logic [amg_pkg::DEG_W-1:0]         in_degree,
	output logic [amg_pkg::VTOT_W-1:0]        vertex_total,
	output logic [amg_pkg::ETOT_W-1:0]        edge_total,
	output logic                              last
);
	import amg_pkg::*;

	localparam int IW   = $clog2(MV);
	localparam int NW   = $clog2(MV + 1);
	localparam int CW   = $clog2(MV * MV);
	localparam int EW   = $clog2(MV * MV + 1);
	localparam int NC   = MV * MV;

	logic [OP_W-1:0]  op_q;
	logic [KEY_W-1:0] skey_q, dkey_q;
	logic [VW-1:0]    nval_q;

	logic [KEY_W-1:0] key_q [MV];
	logic [NW-1:0]    outc_q [MV];
	logic [NW-1:0]    inc_q [MV];
	logic [NW-1:0]    vcnt_q;
	logic [EW-1:0]    ecnt_q;
	logic [NC-1:0]    pres_q;

	logic          s_hit_q, d_hit_q;
	logic [IW-1:0] s_id_q, d_id_q;
	logic [MV-1:0] row_q;
	logic [IW-1:0] j_q;
	logic [STAT_W-1:0] st_q;
	logic          found_q;
	logic [VW-1:0] val_q;
	logic          deg_vld_q;
	logic [IW-1:0] deg_id_q;

	logic          out_valid_q;
	logic [STAT_W-1:0] o_status_q;
	logic          o_found_q, o_last_q;
	logic [OVAL_W-1:0] o_val_q;
	logic [KEY_W-1:0]  o_nkey_q;
	logic [DEG_W-1:0]  o_odeg_q, o_ideg_q;
	logic [VTOT_W-1:0] o_vtot_q;
	logic [ETOT_W-1:0] o_etot_q;

	logic          s_hit, d_hit;
	logic [IW-1:0] s_id, d_id;
	logic [CW-1:0] cidx, cell_m, raddr;
	logic          p_c, p_m, ok_edge, full, can_load;
	logic [MV-1:0] row, above;
	logic [VW-1:0] rdata;
	logic          we;
	logic [CW-1:0] waddr;
	logic [IW-1:0] vnew;

	// associative key match over the ids in use
	always_comb begin
		s_hit = 1'b0;
		d_hit = 1'b0;
		s_id  = '0;
		d_id  = '0;
		for (int k = 0; k < MV; k++) begin
			if (NW'(k) < vcnt_q && key_q[k] == skey_q) begin
				s_hit = 1'b1;
				s_id  = s_id | IW'(k);
			end
			if (NW'(k) < vcnt_q && key_q[k] == dkey_q) begin
				d_hit = 1'b1;
				d_id  = d_id | IW'(k);
			end
		end
	end

	assign raddr   = CW'(s_id) * CW'(MV) + CW'(d_id);
	assign cidx    = CW'(s_id_q) * CW'(MV) + CW'(d_id_q);
	assign cell_m  = CW'(d_id_q) * CW'(MV) + CW'(s_id_q);
	assign p_c     = pres_q[cidx];
	assign p_m     = pres_q[cell_m];
	assign ok_edge = s_hit_q && d_hit_q;
	assign full    = vcnt_q >= NW'(MV);
	assign vnew    = vcnt_q[IW-1:0];

	always_comb begin
		for (int k = 0; k < MV; k++) begin
			if (op_q == OP_SUCC) row[k] = pres_q[CW'(s_id_q) * CW'(MV) + CW'(k)];
			else row[k] = pres_q[CW'(k) * CW'(MV) + CW'(s_id_q)];
			above[k] = row_q[k] && (IW'(k) > j_q);
		end
	end

	assign can_load = !out_valid_q || out_ready;

	always_comb begin
		stat             = '0;
		stat.is_nop      = op_q == OP_NONE;
		stat.is_list     = (op_q == OP_SUCC || op_q == OP_PRED) && s_hit_q;
		stat.need_mirror = ((op_q == OP_ADD_EDGE) || (op_q == OP_REM_EDGE && p_c)) &&
			ok_edge && !directed && (s_id_q != d_id_q);
		stat.row_empty   = ~|row_q;
		stat.row_bit     = row_q[j_q];
		stat.rest_zero   = ~|above;
		stat.can_load    = can_load;
	end

	assign we    = (cmd.exec || cmd.mirror) && op_q == OP_ADD_EDGE && ok_edge;
	assign waddr = cmd.mirror ? cell_m : cidx;

	amg_ram #(.W(VW), .D(NC)) u_edge_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (nval_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	// control state with reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcnt_q      <= '0;
			ecnt_q      <= '0;
			pres_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				case (op_q)
					OP_ADD_VERTEX: if (!s_hit_q && !full) vcnt_q <= vcnt_q + NW'(1);
					OP_ADD_EDGE: begin
						if (ok_edge) begin
							pres_q[cidx] <= 1'b1;
							if (!p_c) ecnt_q <= ecnt_q + EW'(1);
						end
					end
					OP_REM_EDGE: begin
						if (ok_edge && p_c) begin
							pres_q[cidx] <= 1'b0;
							if (ecnt_q != '0) ecnt_q <= ecnt_q - EW'(1);
						end
					end
					default: ;
				endcase
			end
			if (cmd.mirror) begin
				pres_q[cell_m] <= op_q == OP_ADD_EDGE;
			end
			if (cmd.load_single || cmd.load_nbr) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= op;
			skey_q <= src_key;
			dkey_q <= dst_key;
			nval_q <= VW'(new_value);
		end
		if (cmd.match) begin
			s_hit_q <= s_hit;
			d_hit_q <= d_hit;
			s_id_q  <= s_id;
			d_id_q  <= d_id;
		end
		if (cmd.exec) begin
			row_q     <= row;
			j_q       <= '0;
			found_q   <= 1'b0;
			val_q     <= '0;
			deg_vld_q <= 1'b1;
			deg_id_q  <= s_id_q;
			st_q      <= ST_OK;
			if (op_q == OP_ADD_VERTEX) begin
				if (s_hit_q) begin
					st_q <= ST_DUP;
				end else if (full) begin
					st_q      <= ST_FULL;
					deg_vld_q <= 1'b0;
				end else begin
					deg_id_q      <= vnew;
					key_q[vnew]   <= skey_q;
					outc_q[vnew]  <= '0;
					inc_q[vnew]   <= '0;
				end
			end else if (!s_hit_q) begin
				st_q      <= ST_UNKNOWN;
				deg_vld_q <= 1'b0;
			end else if (op_q == OP_ADD_EDGE || op_q == OP_REM_EDGE ||
					op_q == OP_READ_EDGE) begin
				if (!d_hit_q) begin
					st_q <= ST_UNKNOWN;
				end else begin
					case (op_q)
						OP_ADD_EDGE: begin
							if (!p_c) begin
								outc_q[s_id_q] <= outc_q[s_id_q] + NW'(1);
								inc_q[d_id_q]  <= inc_q[d_id_q] + NW'(1);
							end
						end
						OP_REM_EDGE: begin
							if (p_c) begin
								if (outc_q[s_id_q] != '0)
									outc_q[s_id_q] <= outc_q[s_id_q] - NW'(1);
								if (inc_q[d_id_q] != '0)
									inc_q[d_id_q] <= inc_q[d_id_q] - NW'(1);
							end else begin
								st_q <= ST_NO_EDGE;
							end
						end
						default: begin
							if (p_c) begin
								found_q <= 1'b1;
								val_q   <= rdata;
							end else begin
								st_q <= ST_NO_EDGE;
							end
						end
					endcase
				end
			end
		end
		if (cmd.mirror) begin
			if (op_q == OP_ADD_EDGE) begin
				if (!p_m) begin
					outc_q[d_id_q] <= outc_q[d_id_q] + NW'(1);
					inc_q[s_id_q]  <= inc_q[s_id_q] + NW'(1);
				end
			end else if (p_m) begin
				if (outc_q[d_id_q] != '0) outc_q[d_id_q] <= outc_q[d_id_q] - NW'(1);
				if (inc_q[s_id_q] != '0) inc_q[s_id_q] <= inc_q[s_id_q] - NW'(1);
			end
		end
		if (cmd.scan_inc) j_q <= j_q + IW'(1);
		if (cmd.load_single || cmd.load_nbr) begin
			o_odeg_q <= deg_vld_q ? DEG_W'(outc_q[deg_id_q]) : '0;
			o_ideg_q <= deg_vld_q ? DEG_W'(inc_q[deg_id_q]) : '0;
			o_vtot_q <= VTOT_W'(vcnt_q);
			o_etot_q <= ETOT_W'(ecnt_q);
			if (cmd.load_nbr) begin
				o_status_q <= ST_OK;
				o_found_q  <= 1'b1;
				o_val_q    <= '0;
				o_nkey_q   <= key_q[j_q];
				o_last_q   <= ~|above;
			end else begin
				o_status_q <= st_q;
				o_found_q  <= found_q;
				o_val_q    <= OVAL_W'(val_q);
				o_nkey_q   <= '0;
				o_last_q   <= 1'b1;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = o_status_q;
	assign found         = o_found_q;
	assign stored_value  = o_val_q;
	assign neighbour_key = o_nkey_q;
	assign out_degree    = o_odeg_q;
	assign in_degree     = o_ideg_q;
	assign vertex_total  = o_vtot_q;
	assign edge_total    = o_etot_q;
	assign last          = o_last_q;
endmodule
`default_nettype wire

### rtl/adjacency_matrix_graph_store_unit.sv
// top level of the adjacency matrix graph store
// Usage: one operation per slave transaction; tuser carries the op code,
// tdata carries src_key, dst_key and new_value. Each operation but the unused
// op code yields one master transaction, or for a neighbour listing one per
// neighbour in id order, tlast marking the final one.
// Sequence: an operation is matched once accepted and executed after the match,
// with an extra mirror step for the mirror cell of an undirected edge; the
// result is then loaded into the output register once that register is free.
// An unused op code returns to idle after the match without a result. A listing
// scans one vertex id per cycle up to its last neighbour, pausing at a
// neighbour while the output register cannot be loaded; an empty list yields a
// single result.
// The input side accepts a new operation only once the previous one has been
// fully loaded into the output register; a result waiting there does not
// hold the next operation back until another result must be loaded.
// A stalled receiver holds the output register, and the scan halts at the next neighbour.
// Reset clears the vertex and edge counts, all edge present bits and sets
// the directed register; no clearing pass is needed.
// cfg_data bit 0 selects directed (1) or undirected (0) mode, to be written only
// while the block is idle; the user must keep to this, the block does not enforce it.
`default_nettype none
module adjacency_matrix_graph_store_unit #(
	parameter int MAX_VERTICES = 16,
	parameter int VALUE_WIDTH  = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic                              cfg_data,        // directed
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// src_key, dst_key, new_value
	input  wire logic [amg_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	input  wire logic [amg_pkg::OP_W-1:0]          s_axis_tuser,    // op
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// status, found, stored_value, neighbour_key, out_degree, in_degree,
	// vertex_total, edge_total, zero pad
	output logic [amg_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
	output logic                                   m_axis_tlast
);
	import amg_pkg::*;

	logic      directed_q;
	amg_cmd_t  cmd;
	amg_stat_t stat;

	logic [STAT_W-1:0] status;
	logic              found;
	logic [OVAL_W-1:0] stored_value;
	logic [KEY_W-1:0]  neighbour_key;
	logic [DEG_W-1:0]  out_degree, in_degree;
	logic [VTOT_W-1:0] vertex_total;
	logic [ETOT_W-1:0] edge_total;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			directed_q <= 1'b1;
		end else if (cfg_valid) begin
			directed_q <= cfg_data;
		end
	end

	amg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	amg_dp #(.MV(MAX_VERTICES), .VW(VALUE_WIDTH)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.directed      (directed_q),
		.op            (s_axis_tuser),
		.src_key       (s_axis_tdata[31:0]),
		.dst_key       (s_axis_tdata[63:32]),
		.new_value     (s_axis_tdata[95:64]),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.status        (status),
		.found         (found),
		.stored_value  (stored_value),
		.neighbour_key (neighbour_key),
		.out_degree    (out_degree),
		.in_degree     (in_degree),
		.vertex_total  (vertex_total),
		.edge_total    (edge_total),
		.last          (m_axis_tlast)
	);

	assign m_axis_tdata = {4'b0000, edge_total, vertex_total, in_degree, out_degree,
		neighbour_key, stored_value, found, status};

	a_one_op_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("operation accepted while another is in flight");

	a_found_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && found |-> status == ST_OK)
		else $error("found result with failing status");

	a_value_only_when_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !found |-> stored_value == '0)
		else $error("edge value without a found edge");
endmodule
`default_nettype wire
